/* design/ahn_pkg.sv */
// Package with shared types and constants of the angle histogram normalizer.
`timescale 1ns / 1ps
package ahn_pkg;
    localparam int NumClassesDef = 16;
    localparam int MaxBinsDef    = 4096;

    localparam int BwW   = 25;
    localparam int IbwW  = 30;
    localparam int BcW   = 13;
    localparam int CntW  = 32;
    localparam int GtW   = 40;
    localparam int DenW  = 32;
    localparam int CtrW  = 25;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] CFG_BW  = 2'd0;
    localparam logic [1:0] CFG_IBW = 2'd1;
    localparam logic [1:0] CFG_BC  = 2'd2;

    // 180/pi in Q20.
    localparam logic signed [26:0] RAD2DEG_Q20 = 27'sd60078979;
    localparam logic signed [57:0] DEG180_Q47  = 58'sd180 <<< 47;
    localparam logic signed [57:0] DEG360_Q47  = 58'sd360 <<< 47;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  class_sel;
        logic [31:0] angle;
        logic [11:0] bin_sel;
    } t_req;

    typedef struct packed {
        logic [31:0] raw_count;
        logic [31:0] density;
        logic [24:0] bin_center;
    } t_rsp;
endpackage

/* design/ahn_if.sv */
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface ahn_req_if;
    logic           valid;
    logic           ready;
    ahn_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ahn_rsp_if;
    logic           valid;
    logic           ready;
    ahn_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ahn_divider.sv */
// Restoring divider for the density quotient, one quotient bit per cycle.
`timescale 1ns / 1ps
module ahn_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_count,
    input  logic [64:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    // Numerator is count << 40, 72 bits; quotient bits above 31 mean saturation.
    logic [71:0] r_num;
    logic [72:0] r_rem;
    logic [64:0] r_den;
    logic [31:0] r_q;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_sat;
    logic        r_done;
    logic [72:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[71:0], r_num[71]};
    assign w_ge = w_sh >= {8'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 7'd0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= {i_count, 40'd0};
                r_rem  <= '0;
                r_den  <= i_den;
                r_q    <= '0;
                r_sat  <= 1'b0;
                r_cnt  <= 7'd71;
            end else if (r_busy) begin
                r_num <= {r_num[70:0], 1'b0};
                r_rem <= w_ge ? w_sh - {8'd0, r_den} : w_sh;
                if (w_ge && r_cnt >= 7'd32) r_sat <= 1'b1;
                r_q   <= {r_q[30:0], w_ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? 32'hFFFF_FFFF : r_q;
endmodule

/* design/ahn_core.sv */
// Sequencer with class and total count memories, read-modify-write per item.
`timescale 1ns / 1ps
module ahn_core #(
    parameter int NUM_CLASSES = ahn_pkg::NumClassesDef,
    parameter int MAX_BINS    = ahn_pkg::MaxBinsDef
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [29:0] i_cfg_data,
    ahn_req_if.sink   s_req,
    ahn_rsp_if.source m_rsp
);
    localparam int BW  = $clog2(MAX_BINS);
    localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int AW  = CW + BW;
    localparam int TD  = 2 ** BW;
    localparam int CD  = NUM_CLASSES * TD;
    localparam int NBW = $clog2(MAX_BINS + 1);

    typedef enum logic [9:0] {
        ST_CLR   = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_CONV  = 10'b0000000100,
        ST_SCALE = 10'b0000001000,
        ST_BIN   = 10'b0000010000,
        ST_RD    = 10'b0000100000,
        ST_WR    = 10'b0001000000,
        ST_MUL   = 10'b0010000000,
        ST_DIV   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    t_state r_st;
    logic [24:0] r_bw;
    logic [29:0] r_ibw;
    logic [12:0] r_bc;
    logic [39:0] r_gt;
    ahn_pkg::t_req r_req;
    logic [57:0] r_deg;
    logic [34:0] r_s24;
    logic [BW-1:0] r_bin;
    logic        r_drop;
    logic [AW-1:0] r_clr;
    logic [31:0] r_cmem [CD];
    logic [31:0] r_tmem [TD];
    logic [31:0] r_crd, r_trd;
    logic [31:0] r_cnt;
    logic [64:0] r_den;
    logic [31:0] r_dens;
    logic        r_start;
    logic        r_ov;
    ahn_pkg::t_rsp r_rsp;
    logic          r_rsp_v;

    logic [NBW-1:0] w_nbins;
    logic [34:0] w_s24;
    logic [64:0] w_prod;
    logic [24:0] w_binr;
    logic [CW-1:0] w_cls;
    logic [AW-1:0] w_caddr;
    logic        w_dd;
    logic [31:0] w_dq;
    logic [BW-1:0] w_bsel;
    logic [49:0] w_cprod;
    logic signed [51:0] w_ctr;
    logic [24:0] w_ctrs;

    assign w_nbins = (32'(r_bc) < 32'(MAX_BINS)) ? NBW'(r_bc) : NBW'(MAX_BINS);

    // Offset of the wrapped angle, then the bin index from the reciprocal width.
    assign w_s24  = 35'((r_deg + ahn_pkg::DEG180_Q47) >> 23);
    assign w_prod = r_s24 * r_ibw;
    assign w_binr = w_prod[64:40];

    assign w_cls   = CW'(r_req.class_sel);
    assign w_bsel  = BW'(r_req.bin_sel);
    assign w_caddr = (r_st == ST_CLR) ? r_clr :
                     {w_cls, (r_req.func == ahn_pkg::FUNC_ADD) ? r_bin : w_bsel};

    // Memories: one port each, registered read.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_CLR)
            r_cmem[r_clr] <= '0;
        else if (r_st == ST_WR && !r_drop)
            r_cmem[w_caddr] <= (r_crd == 32'hFFFF_FFFF) ? r_crd : r_crd + 32'd1;
        r_crd <= r_cmem[w_caddr];
    end
    always_ff @(posedge i_clk) begin
        if (r_st == ST_CLR)
            r_tmem[r_clr[BW-1:0]] <= '0;
        else if (r_st == ST_WR && !r_drop)
            r_tmem[w_caddr[BW-1:0]] <= (r_trd == 32'hFFFF_FFFF) ? r_trd : r_trd + 32'd1;
        r_trd <= r_tmem[w_caddr[BW-1:0]];
    end

    // Bin center, saturated.
    assign w_cprod = {37'd0, r_req.bin_sel, 1'b1} * {25'd0, r_bw};
    assign w_ctr   = $signed({3'd0, w_cprod[49:1]}) - 52'sd11796480;
    assign w_ctrs  = (w_ctr > 52'sd16777215) ? 25'h0FFFFFF :
                     (w_ctr < -52'sd16777216) ? 25'h1000000 : w_ctr[24:0];

    ahn_divider u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_start),
        .i_count (r_cnt), .i_den (r_den), .o_done (w_dd), .o_quot (w_dq)
    );

    assign s_req.ready = (r_st == ST_IDLE) && !r_rsp_v;
    assign m_rsp.valid = r_rsp_v;
    assign m_rsp.data  = r_rsp;

    // Divider start pulse, registered from ST_MUL together with the denominator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= (r_st == ST_MUL) && !(r_ov || r_gt == '0 || r_bw == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_CLR;
            r_clr  <= '0;
            r_bw   <= 25'd65536;
            r_ibw  <= 30'd65536;
            r_bc   <= 13'd361;
            r_gt   <= '0;
            r_rsp_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ahn_pkg::CFG_BW:  r_bw  <= i_cfg_data[24:0];
                    ahn_pkg::CFG_IBW: r_ibw <= i_cfg_data;
                    ahn_pkg::CFG_BC:  r_bc  <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (r_rsp_v && m_rsp.ready) r_rsp_v <= 1'b0;
            case (r_st)
                ST_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CD - 1)) r_st <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_req.valid && s_req.ready) begin
                        r_req <= s_req.data;
                        r_deg <= 58'($signed(s_req.data.angle) * ahn_pkg::RAD2DEG_Q20);
                        case (s_req.data.func)
                            ahn_pkg::FUNC_ADD: begin
                                if (32'(s_req.data.class_sel) >= 32'(NUM_CLASSES)
                                    || w_nbins == '0)
                                    r_st <= ST_IDLE;
                                else
                                    r_st <= ST_CONV;
                            end
                            ahn_pkg::FUNC_READ: r_st <= ST_RD;
                            ahn_pkg::FUNC_CLEAR: begin
                                r_gt  <= '0;
                                r_clr <= '0;
                                r_st  <= ST_CLR;
                            end
                            default: r_st <= ST_IDLE;
                        endcase
                    end
                end
                // One turn per cycle until the angle lies in (-180,180].
                ST_CONV: begin
                    if ($signed(r_deg) <= -ahn_pkg::DEG180_Q47) begin
                        r_deg <= r_deg + ahn_pkg::DEG360_Q47;
                    end else if ($signed(r_deg) > ahn_pkg::DEG180_Q47) begin
                        r_deg <= r_deg - ahn_pkg::DEG360_Q47;
                    end else begin
                        r_s24 <= w_s24;
                        r_st  <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_drop <= ({7'd0, w_binr} > 32'(w_nbins));
                    r_bin  <= (32'(w_binr) >= 32'(w_nbins)) ? BW'(w_nbins - NBW'(1))
                                                           : BW'(w_binr);
                    r_st   <= ST_BIN;
                end
                ST_BIN: r_st <= ST_WR;
                ST_WR: begin
                    if (!r_drop && r_gt != 40'hFF_FFFF_FFFF) r_gt <= r_gt + 40'd1;
                    r_st <= ST_IDLE;
                end
                ST_RD: begin
                    r_ov <= 32'(r_req.bin_sel) >= 32'(MAX_BINS);
                    r_st <= ST_MUL;
                end
                ST_MUL: begin
                    r_cnt <= r_ov ? 32'd0 :
                             (32'(r_req.class_sel) < 32'(NUM_CLASSES)) ? r_crd : r_trd;
                    r_den <= r_gt * r_bw;
                    if (r_ov || r_gt == '0 || r_bw == '0) begin
                        r_dens <= '0;
                        r_st   <= ST_OUT;
                    end else begin
                        r_st    <= ST_DIV;
                    end
                end
                ST_DIV: if (w_dd) begin
                    r_dens <= w_dq;
                    r_st   <= ST_OUT;
                end
                ST_OUT: begin
                    r_rsp.raw_count  <= r_cnt;
                    r_rsp.density    <= r_dens;
                    r_rsp.bin_center <= w_ctrs;
                    r_rsp_v <= 1'b1;
                    r_st    <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

/* design/angle_histogram_normalizer.sv */
// Top level of the angle histogram normalizer.
// One item is taken at a time. An add holds the input closed after its beat
// while it wraps the angle one turn per cycle, scales it to a bin, reads the
// memories and writes the increments, and the next beat is taken after that.
// An add that is dropped for a bad class or zero bins in use, and an unused
// function code, let the next beat in on the following cycle. A read passes
// the memory read, the multiply and, unless the density is zero, the bit-serial
// 72-step density divider before its result is presented; the next beat is
// taken in the cycle after the result beat leaves. A clear, and reset, sweep
// the class and total memories one entry a cycle with no item accepted;
// configuration writes are taken at any time.
`timescale 1ns / 1ps
module angle_histogram_normalizer #(
    parameter int NUM_CLASSES = ahn_pkg::NumClassesDef,
    parameter int MAX_BINS    = ahn_pkg::MaxBinsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [29:0] i_cfg_data,
    ahn_req_if.sink     s_req,
    ahn_rsp_if.source   m_rsp
);
    ahn_core #(.NUM_CLASSES(NUM_CLASSES), .MAX_BINS(MAX_BINS)) u_core (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_cfg_we (i_cfg_we),
        .i_cfg_idx (i_cfg_idx), .i_cfg_data (i_cfg_data),
        .s_req (s_req), .m_rsp (m_rsp)
    );
endmodule

/* design/ahn_checker.sv */
// Port-level checker for the angle histogram normalizer, bound to the top level.
`timescale 1ns / 1ps
module ahn_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready
);
    a_no_ready_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !req_ready) else $error("ready after reset");
    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !rsp_valid) else $error("response after reset");
    a_rsp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
    a_no_take_while_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |-> !rsp_valid) else $error("item taken with result waiting");
endmodule

bind angle_histogram_normalizer ahn_checker u_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n),
    .req_valid (s_req.valid), .req_ready (s_req.ready),
    .rsp_valid (m_rsp.valid), .rsp_ready (m_rsp.ready)
);
